// File: rtl/core/ale_pkg.sv
// Shared types and codes for the array list engine.
// No dependencies; imported by the memory, the sequencer, the top level and the checker.
`default_nettype none

package ale_pkg;

	// One stored list word
	typedef logic signed [31:0] word_t;

	// Command codes
	localparam logic [3:0] CMD_INS_HEAD = 4'd0;
	localparam logic [3:0] CMD_INS_TAIL = 4'd1;
	localparam logic [3:0] CMD_INS_POS  = 4'd2;
	localparam logic [3:0] CMD_DEL_HEAD = 4'd3;
	localparam logic [3:0] CMD_DEL_TAIL = 4'd4;
	localparam logic [3:0] CMD_DEL_POS  = 4'd5;
	localparam logic [3:0] CMD_DEL_VAL  = 4'd6;
	localparam logic [3:0] CMD_DEDUPE   = 4'd7;
	localparam logic [3:0] CMD_CLEAR    = 4'd8;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// File: rtl/core/array_list_engine.sv
// Array list engine: ordered list of signed words with insert, delete, dedupe, clear.
// Errors, clear and unused codes go straight to the result beat; insert shifts later words up,
// deletes compact the list, dedupe compares each word with the words after it; the store is
// walked a word a cycle through its read port and its write port.
// One command at a time: busy is high from accept until the done beat; the receiver cannot stall.
// Reset clears the entry count and control; store contents are not cleared.
`default_nettype none

module array_list_engine
	import ale_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [3:0] cmd,
	input  wire logic [4:0] position,
	input  wire word_t      value,
	output logic            busy,
	output logic            done,
	output logic [2:0]      status,
	output word_t           removed_word,
	output logic [4:0]      entry_count,
	output logic            is_empty,
	output logic            is_full
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic [AW-1:0] mem_raddr;
	word_t         mem_rdata;

	// Sequencer with the shared compare
	ale_ctrl #(
		.LIST_DEPTH (LIST_DEPTH),
		.AW         (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.position     (position),
		.value        (value),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.removed_word (removed_word),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// List word store
	ale_mem #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// File: rtl/core/ale_mem.sv
// Word store of the list: one write port, one read port with registered data.
// Depends on ale_pkg for the word type.
`default_nettype none

module ale_mem
	import ale_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire word_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output word_t              rdata
);

	word_t mem_q [DEPTH];

	// Write one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one word; the read data is registered
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/ale_ctrl.sv
// Command sequencer of the array list engine: decodes a command, walks the
// store one word a cycle through a shared equality compare. Uses ale_pkg.
`default_nettype none

module ale_ctrl
	import ale_pkg::*;
#(
	parameter int LIST_DEPTH = 16,
	parameter int AW         = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [3:0]    cmd,
	input  wire logic [4:0]    position,
	input  wire word_t         value,
	output logic               busy,
	output logic               done,
	output logic [2:0]         status,
	output word_t              removed_word,
	output logic [4:0]         entry_count,
	output logic               is_empty,
	output logic               is_full,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output word_t              mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  wire word_t         mem_rdata
);

	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHUP  = 3'd1;
	localparam logic [2:0] S_COMP  = 3'd2;
	localparam logic [2:0] S_DRI   = 3'd3;
	localparam logic [2:0] S_DGET  = 3'd4;
	localparam logic [2:0] S_DSCAN = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] j_q;
	logic          v_s1;
	logic [CW-1:0] i_s1;
	logic          delpos_q;
	word_t         val_q;
	word_t         cur_q;
	logic [2:0]    status_q;
	word_t         removed_q;
	logic [4:0]    ecount_q;
	logic          empty_q;
	logic          full_q;
	logic          done_q;

	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	logic [CW-1:0]   pos_idx;
	logic            pos_bad;
	logic            is_full_now;
	logic [CW-1:0]   p_inc;
	logic [CW-1:0]   p_dec;
	logic [CW-1:0]   j_inc;
	logic            p_above;
	logic            p_below;
	word_t           cmp_opnd;
	logic            cmp_eq;
	logic            keep;
	logic [2:0]      acc_state;
	logic [2:0]      acc_status;

	// Position check against the current entry count
	assign pos_ext     = CMPW'(position);
	assign cnt_ext     = CMPW'(count_q);
	assign pos_bad     = (pos_ext == '0) || (pos_ext > cnt_ext);
	assign pos_idx     = CW'(pos_ext - CMPW'(1));
	assign is_full_now = (count_q == DEPTH_C);

	assign p_inc   = p_q + ONE_C;
	assign p_dec   = p_q - ONE_C;
	assign j_inc   = j_q + ONE_C;
	assign p_above = (p_q > idx_q);
	assign p_below = (p_q < count_q);

	// Shared equality compare: read word against the held value or the current word
	assign cmp_opnd = (state_q == S_DSCAN) ? cur_q : val_q;
	assign cmp_eq   = (mem_rdata == cmp_opnd);
	assign keep     = delpos_q ? (i_s1 != idx_q) : !cmp_eq;

	// Decode the command into its first state and its status
	always_comb begin
		acc_state  = S_FIN;
		acc_status = ST_OK;
		unique case (cmd)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
				if (is_full_now) begin
					acc_status = ST_FULL;
				end else if (cmd == CMD_INS_POS && pos_bad) begin
					acc_status = ST_BADPOS;
				end else begin
					acc_state = S_SHUP;
				end
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
				if (count_q == '0) begin
					acc_status = ST_EMPTY;
				end else if (cmd == CMD_DEL_POS && pos_bad) begin
					acc_status = ST_BADPOS;
				end else begin
					acc_state = S_COMP;
				end
			end
			CMD_DEL_VAL: begin
				acc_state = S_COMP;
			end
			CMD_DEDUPE: begin
				acc_state = S_DRI;
			end
			CMD_CLEAR: begin
				if (count_q == '0) begin
					acc_status = ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Drive the store ports from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			S_SHUP: begin
				if (p_above) begin
					mem_raddr = p_dec[AW-1:0];
				end
				if (v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = i_s1[AW-1:0];
					mem_wdata = mem_rdata;
				end else if (!p_above) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[AW-1:0];
					mem_wdata = val_q;
				end
			end
			S_COMP: begin
				if (p_below) begin
					mem_raddr = p_q[AW-1:0];
				end
				if (v_s1 && keep) begin
					mem_we    = 1'b1;
					mem_waddr = n_q[AW-1:0];
					mem_wdata = mem_rdata;
				end
			end
			S_DRI: begin
				mem_raddr = p_q[AW-1:0];
			end
			S_DGET: begin
				if (p_inc < count_q) begin
					mem_raddr = p_inc[AW-1:0];
				end else begin
					mem_we    = 1'b1;
					mem_waddr = n_q[AW-1:0];
					mem_wdata = mem_rdata;
				end
			end
			S_DSCAN: begin
				if (!cmp_eq) begin
					if (j_inc < count_q) begin
						mem_raddr = j_inc[AW-1:0];
					end else begin
						mem_we    = 1'b1;
						mem_waddr = n_q[AW-1:0];
						mem_wdata = cur_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			p_q       <= '0;
			n_q       <= '0;
			j_q       <= '0;
			v_s1      <= 1'b0;
			i_s1      <= '0;
			delpos_q  <= 1'b0;
			val_q     <= '0;
			cur_q     <= '0;
			status_q  <= ST_OK;
			removed_q <= '0;
			ecount_q  <= '0;
			empty_q   <= 1'b1;
			full_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q     <= value;
						removed_q <= '0;
						status_q  <= acc_status;
						v_s1      <= 1'b0;
						state_q   <= acc_state;
						unique case (cmd)
							CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
								if (acc_state == S_SHUP) begin
									p_q <= count_q;
									if (cmd == CMD_INS_HEAD) begin
										idx_q <= '0;
									end else if (cmd == CMD_INS_TAIL) begin
										idx_q <= count_q;
									end else begin
										idx_q <= pos_idx;
									end
								end
							end
							CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
								if (acc_state == S_COMP) begin
									delpos_q <= 1'b1;
									if (cmd == CMD_DEL_HEAD) begin
										idx_q <= '0;
										p_q   <= '0;
										n_q   <= '0;
									end else if (cmd == CMD_DEL_TAIL) begin
										idx_q <= count_q - ONE_C;
										p_q   <= count_q - ONE_C;
										n_q   <= count_q - ONE_C;
									end else begin
										idx_q <= pos_idx;
										p_q   <= pos_idx;
										n_q   <= pos_idx;
									end
								end
							end
							CMD_DEL_VAL: begin
								delpos_q <= 1'b0;
								idx_q    <= '0;
								p_q      <= '0;
								n_q      <= '0;
							end
							CMD_DEDUPE: begin
								p_q <= '0;
								n_q <= '0;
							end
							CMD_CLEAR: begin
								if (acc_status == ST_OK) begin
									count_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// Shift entries up one slot from the tail down, then drop in the word
				S_SHUP: begin
					if (p_above) begin
						v_s1 <= 1'b1;
						i_s1 <= p_q;
						p_q  <= p_dec;
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							count_q <= count_q + ONE_C;
							state_q <= S_FIN;
						end
					end
				end
				// Compact: read in order, write back kept words, drop the rest
				S_COMP: begin
					if (p_below) begin
						v_s1 <= 1'b1;
						i_s1 <= p_q;
						p_q  <= p_inc;
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (keep) begin
							n_q <= n_q + ONE_C;
						end else if (delpos_q) begin
							removed_q <= mem_rdata;
						end
					end
					if (!p_below && !v_s1) begin
						count_q <= n_q;
						if (!delpos_q && n_q == count_q) begin
							status_q <= ST_NOTFOUND;
						end
						state_q <= S_FIN;
					end
				end
				// Dedupe: fetch the next candidate word, or finish when none is left
				S_DRI: begin
					if (p_below) begin
						state_q <= S_DGET;
					end else begin
						count_q <= n_q;
						state_q <= S_FIN;
					end
				end
				// Hold the candidate; keep it at once if nothing follows
				S_DGET: begin
					cur_q <= mem_rdata;
					if (p_inc < count_q) begin
						j_q     <= p_inc;
						state_q <= S_DSCAN;
					end else begin
						n_q     <= n_q + ONE_C;
						p_q     <= p_inc;
						state_q <= S_DRI;
					end
				end
				// Scan later words; a match drops the candidate
				S_DSCAN: begin
					if (cmp_eq) begin
						p_q     <= p_inc;
						state_q <= S_DRI;
					end else if (j_inc < count_q) begin
						j_q <= j_inc;
					end else begin
						n_q     <= n_q + ONE_C;
						p_q     <= p_inc;
						state_q <= S_DRI;
					end
				end
				// Load the result beat
				S_FIN: begin
					ecount_q <= cnt_ext[4:0];
					empty_q  <= (count_q == '0);
					full_q   <= is_full_now;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign removed_word = removed_q;
	assign entry_count  = ecount_q;
	assign is_empty     = empty_q;
	assign is_full      = full_q;

endmodule

`default_nettype wire

// File: rtl/core/ale_chk.sv
// Port-level checks of the array list engine, attached by bind.
// Depends on ale_pkg for status codes.
`default_nettype none

module ale_chk
	import ale_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [31:0] removed_word,
	input wire logic        is_empty,
	input wire logic        is_full
);

	// A result beat comes only once the engine is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted command keeps the engine busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// The result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held over two cycles");

	// A failed command removes nothing
	a_err_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (removed_word == '0))
		else $error("removed word on failed command");

	// Empty and full never both hold on a result beat
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty && is_full))
		else $error("list reported empty and full");

endmodule

bind array_list_engine ale_chk u_ale_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.removed_word (removed_word),
	.is_empty     (is_empty),
	.is_full      (is_full)
);

`default_nettype wire
